// File: hw/rtl/lua_tok_pkg.sv
// ----------------------------------------------------------------------------
// lua_tok_pkg
// shared types, token codes and byte classes for the lua tokenizer
// ----------------------------------------------------------------------------
package lua_tok_pkg;

  localparam int NameBytes  = 8;
  localparam int LengthBits = 16;
  localparam int KindBits   = 6;
  localparam int LenOutBits = 16;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;

  typedef logic [LengthBits-1:0] len_t;
  typedef logic [KindBits-1:0]   kind_t;

  // token kind codes
  localparam kind_t K_INT    = 6'd22;
  localparam kind_t K_FLOAT  = 6'd23;
  localparam kind_t K_STR    = 6'd24;
  localparam kind_t K_USTR   = 6'd25;
  localparam kind_t K_IDENT  = 6'd26;
  localparam kind_t K_ASSIGN = 6'd27;
  localparam kind_t K_GE     = 6'd28;
  localparam kind_t K_LE     = 6'd29;
  localparam kind_t K_EQ     = 6'd30;
  localparam kind_t K_NE     = 6'd31;
  localparam kind_t K_GT     = 6'd32;
  localparam kind_t K_LT     = 6'd33;
  localparam kind_t K_ADD    = 6'd34;
  localparam kind_t K_SUB    = 6'd35;
  localparam kind_t K_MUL    = 6'd36;
  localparam kind_t K_DIV    = 6'd37;
  localparam kind_t K_MOD    = 6'd38;
  localparam kind_t K_POW    = 6'd39;
  localparam kind_t K_LEN    = 6'd40;
  localparam kind_t K_SCOM   = 6'd41;
  localparam kind_t K_LCOM   = 6'd42;
  localparam kind_t K_LPAR   = 6'd43;
  localparam kind_t K_RPAR   = 6'd44;
  localparam kind_t K_LBRACK = 6'd45;
  localparam kind_t K_RBRACK = 6'd46;
  localparam kind_t K_LBRACE = 6'd47;
  localparam kind_t K_RBRACE = 6'd48;
  localparam kind_t K_DCOLON = 6'd51;
  localparam kind_t K_COLON  = 6'd52;
  localparam kind_t K_COMMA  = 6'd53;
  localparam kind_t K_SEMI   = 6'd54;
  localparam kind_t K_ATTR   = 6'd55;
  localparam kind_t K_UNID   = 6'd57;
  localparam kind_t K_EOF    = 6'd58;

  // byte class from the front part
  typedef struct packed {
    logic digit;
    logic alpha;
    logic xdigit;
    logic space;
    logic namech;
  } cls_t;

  // classified byte carried through the queue
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    cls_t       cls;
  } fitem_t;

  // one result
  typedef struct packed {
    kind_t             kind;
    logic [LenOutBits-1:0] len;
  } tok_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r.digit  = (c >= 8'h30) && (c <= 8'h39);
    r.alpha  = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    r.xdigit = r.digit || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    r.space  = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    r.namech = r.alpha || r.digit || (c == 8'h5f);
    return r;
  endfunction

  // keyword lookup on a packed name of up to eight bytes
  function automatic kind_t kw_kind(input logic [63:0] nb, input logic [3:0] n);
    kind_t k;
    k = K_IDENT;
    case (n)
      4'd2: begin
        if (nb[15:0] == 16'h6669) k = 6'd1;       // if
        else if (nb[15:0] == 16'h6e69) k = 6'd2;  // in
        else if (nb[15:0] == 16'h726f) k = 6'd6;  // or
        else if (nb[15:0] == 16'h6f64) k = 6'd20; // do
      end
      4'd3: begin
        if (nb[23:0] == 24'h6c696e) k = 6'd3;       // nil
        else if (nb[23:0] == 24'h746f6e) k = 6'd4;  // not
        else if (nb[23:0] == 24'h646e61) k = 6'd12; // and
        else if (nb[23:0] == 24'h646e65) k = 6'd15; // end
        else if (nb[23:0] == 24'h726f66) k = 6'd17; // for
      end
      4'd4: begin
        if (nb[31:0] == 32'h6e656874) k = 6'd7;       // then
        else if (nb[31:0] == 32'h65757274) k = 6'd8;  // true
        else if (nb[31:0] == 32'h6f746f67) k = 6'd13; // goto
        else if (nb[31:0] == 32'h65736c65) k = 6'd18; // else
      end
      4'd5: begin
        if (nb[39:0] == 40'h6c61636f6c) k = 6'd0;       // local
        else if (nb[39:0] == 40'h656c696877) k = 6'd9;  // while
        else if (nb[39:0] == 40'h6c69746e75) k = 6'd10; // until
        else if (nb[39:0] == 40'h65736c6166) k = 6'd16; // false
        else if (nb[39:0] == 40'h6b61657262) k = 6'd21; // break
      end
      4'd6: begin
        if (nb[47:0] == 48'h746165706572) k = 6'd5;       // repeat
        else if (nb[47:0] == 48'h6e7275746572) k = 6'd11; // return
        else if (nb[47:0] == 48'h666965736c65) k = 6'd19; // elseif
      end
      4'd8: begin
        if (nb == 64'h6e6f6974636e7566) k = 6'd14; // function
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

// File: hw/rtl/lua_source_tokenizer_core.sv
// ----------------------------------------------------------------------------
// lua_source_tokenizer_core
// streaming lua tokenizer: bytes in, token kind and length out
// ----------------------------------------------------------------------------
// s_axis carries one source byte per item, tlast marks the final byte.
// m_axis carries one token per item: kind and length in tdata, tlast set on
// the last token caused by a given input byte.
// A byte passes a four-entry queue after classification, then the lexer
// state machine updates and loads up to three tokens into the output slot
// registers. The first token of a byte is valid in the cycle after the lexer
// takes that byte from the queue.
// Throughput is one byte per cycle while each byte makes at most one token
// and m_axis_tready is high; a byte that makes two or three tokens holds
// the lexer until the output slots drain, one token a cycle while m_axis_tready is high.
// Reset clears the lexer to the between-tokens state and empties the queue.
// A stalled m_axis_tready holds the output token; the queue absorbs up to
// four more bytes, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module lua_source_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // token_kind [5:0], token_length [21:6], zero fill
  output logic        m_axis_tlast    // run_end
);
  import lua_tok_pkg::*;

  logic   q_valid;
  logic   q_ready;
  fitem_t q_item;
  tok_t   tok;

  lua_tok_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_ch(s_axis_tdata), .in_last(s_axis_tlast),
    .q_valid, .q_ready, .q_item
  );

  lua_tok_back u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_item,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_tok(tok), .out_end(m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, tok.len, tok.kind};

endmodule

// File: hw/rtl/lua_tok_front.sv
// ----------------------------------------------------------------------------
// lua_tok_front
// input stage that classifies bytes and writes them into a short four-entry queue
// ----------------------------------------------------------------------------
module lua_tok_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_ch,
  input  logic                in_last,
  output logic                q_valid,
  input  logic                q_ready,
  output lua_tok_pkg::fitem_t q_item
);
  import lua_tok_pkg::*;

  fitem_t              mem [QueueDepth];
  logic [QueueAw-1:0]  wptr;
  logic [QueueAw-1:0]  rptr;
  logic [QueueAw:0]    count;
  logic                push;
  logic                pop;

  assign in_ready = (count != QueueAw'(0) + (QueueAw+1)'(QueueDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= '{ch: in_ch, last: in_last, cls: classify(in_ch)};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QueueAw+1)'(QueueDepth)) else $error("queue overfilled");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == (QueueAw+1)'(QueueDepth)) |-> !push) else $error("push while full");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1)) else $error("count slip");

endmodule

// File: hw/rtl/lua_tok_back.sv
// ----------------------------------------------------------------------------
// lua_tok_back
// lexer state machine: one byte per cycle unless held by a stalled or multi-token output, up to three tokens per byte
// ----------------------------------------------------------------------------
module lua_tok_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  lua_tok_pkg::fitem_t q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output lua_tok_pkg::tok_t   out_tok,
  output logic                out_end
);
  import lua_tok_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE, M_TILDE, M_GT, M_LT, M_EQ, M_COLON, M_MINUS, M_DASH2, M_DASH2BR,
    M_SCOM, M_LCOM, M_DOT, M_LBRACK, M_LSTR, M_SSTR, M_SESC, M_NUMZERO,
    M_NUMBER, M_NAME
  } mode_t;

  mode_t      mode, mode_next;
  logic [63:0] nbuf, nbuf_next;
  len_t       cnt, cnt_next;
  logic [7:0] quote, quote_next;
  logic [1:0] nflags, nflags_next;
  logic [7:0] held, held_next;

  // result slots for the current byte
  tok_t       slot [3];
  logic [1:0] nres;
  tok_t       res [3];
  logic [1:0] res_n;
  logic [1:0] res_pos;
  logic       busy;

  logic [7:0] c;
  cls_t       k;
  len_t       cnt_b;
  logic       take;

  assign c = q_item.ch;
  assign k = q_item.cls;
  assign q_ready = !busy || (out_ready && (res_pos + 2'd1 == res_n));
  assign take = q_valid && q_ready;
  assign out_valid = busy;
  assign out_tok = res[res_pos];
  assign out_end = (res_pos + 2'd1 == res_n);

  function automatic logic [LenOutBits-1:0] lcap(input len_t l);
    return LenOutBits'(l);
  endfunction

  // next state and results for one byte
  always_comb begin
    logic       relex;
    mode_t      fm;
    logic [1:0] fl;
    mode_t      pm;
    mode_next   = mode;
    nbuf_next   = nbuf;
    cnt_next    = cnt;
    quote_next  = quote;
    nflags_next = nflags;
    held_next   = held;
    nres        = 2'd0;
    relex       = 1'b0;
    fm          = M_IDLE;
    fl          = 2'd0;
    for (int i = 0; i < 3; i++) slot[i] = '0;
    cnt_b = (cnt == '1) ? cnt : cnt + 1'b1;

    pm = mode;
    // zero prefix: x/X makes it hex, else fall into number handling
    if (mode == M_NUMZERO) begin
      if (c == 8'h78 || c == 8'h58) begin
        mode_next = M_NUMBER;
        nflags_next = nflags | 2'b10;
        cnt_next = cnt_b;
        pm = M_IDLE;
      end else begin
        pm = M_NUMBER;
      end
    end

    // pending token
    case (pm)
      M_IDLE: relex = (mode == M_IDLE);
      M_TILDE, M_GT, M_LT, M_EQ, M_COLON: begin
        if (c == ((pm == M_COLON) ? 8'h3a : 8'h3d)) begin
          case (pm)
            M_TILDE: slot[0] = '{K_NE, lcap(cnt_b)};
            M_GT:    slot[0] = '{K_GE, lcap(cnt_b)};
            M_LT:    slot[0] = '{K_LE, lcap(cnt_b)};
            M_EQ:    slot[0] = '{K_EQ, lcap(cnt_b)};
            default: slot[0] = '{K_DCOLON, lcap(cnt_b)};
          endcase
          nres = 2'd1;
          mode_next = M_IDLE;
        end else begin
          case (pm)
            M_TILDE: slot[0] = '{K_UNID, lcap(cnt)};
            M_GT:    slot[0] = '{K_GT, lcap(cnt)};
            M_LT:    slot[0] = '{K_LT, lcap(cnt)};
            M_EQ:    slot[0] = '{K_ASSIGN, lcap(cnt)};
            default: slot[0] = '{K_COLON, lcap(cnt)};
          endcase
          nres = 2'd1;
          relex = 1'b1;
        end
      end
      M_MINUS: begin
        if (c == 8'h2d) begin
          mode_next = M_DASH2; cnt_next = cnt_b;
        end else if (k.digit) begin
          mode_next = M_NUMBER; nflags_next = 2'b00; cnt_next = cnt_b;
        end else begin
          slot[0] = '{K_SUB, lcap(cnt)}; nres = 2'd1; relex = 1'b1;
        end
      end
      M_DASH2, M_DASH2BR, M_SCOM: begin
        if (c == 8'h0a) begin
          slot[0] = '{K_SCOM, lcap(cnt)}; nres = 2'd1; relex = 1'b1;
        end else begin
          if (c == 8'h5b && pm == M_DASH2) mode_next = M_DASH2BR;
          else if (c == 8'h5b && pm == M_DASH2BR) begin
            mode_next = M_LCOM; held_next = c;
          end else mode_next = M_SCOM;
          cnt_next = cnt_b;
        end
      end
      M_LCOM, M_LSTR: begin
        if (c == 8'h5d && held == 8'h5d) begin
          slot[0] = '{(pm == M_LCOM) ? K_LCOM : K_STR, lcap(cnt_b)};
          nres = 2'd1; mode_next = M_IDLE;
        end else begin
          held_next = c; cnt_next = cnt_b;
        end
      end
      M_DOT: begin
        if (k.digit) begin
          mode_next = M_NUMBER; nflags_next = 2'b01; cnt_next = cnt_b;
        end else begin
          slot[0] = '{K_ATTR, lcap(cnt)}; nres = 2'd1; relex = 1'b1;
        end
      end
      M_LBRACK: begin
        if (c == 8'h5b) begin
          mode_next = M_LSTR; held_next = c; cnt_next = cnt_b;
        end else begin
          slot[0] = '{K_LBRACK, lcap(cnt)}; nres = 2'd1; relex = 1'b1;
        end
      end
      M_SSTR: begin
        if (c == 8'h5c) begin
          mode_next = M_SESC; cnt_next = cnt_b;
        end else if (c == quote) begin
          slot[0] = '{K_STR, lcap(cnt_b)}; nres = 2'd1; mode_next = M_IDLE;
        end else cnt_next = cnt_b;
      end
      M_SESC: begin
        mode_next = M_SSTR; cnt_next = cnt_b;
      end
      M_NUMBER: begin
        mode_next = M_NUMBER;
        if (c == 8'h2e) begin
          nflags_next = nflags | 2'b01; cnt_next = cnt_b;
        end else if (c == 8'h2d || k.digit || c == 8'h65 || c == 8'h45 ||
                     (nflags[1] && k.xdigit)) begin
          cnt_next = cnt_b;
        end else begin
          slot[0] = '{nflags[0] ? K_FLOAT : K_INT, lcap(cnt)};
          nres = 2'd1; relex = 1'b1;
        end
      end
      M_NAME: begin
        if (k.namech) begin
          if (cnt < len_t'(NameBytes))
            nbuf_next = nbuf | (64'(c) << {cnt[2:0], 3'b000});
          cnt_next = cnt_b;
        end else begin
          slot[0] = '{(cnt > len_t'(NameBytes)) ? K_IDENT : kw_kind(nbuf, cnt[3:0]),
                      lcap(cnt)};
          nres = 2'd1; relex = 1'b1;
        end
      end
      default: relex = 1'b1;
    endcase

    // fresh token start
    if (relex) begin
      mode_next = M_IDLE; nbuf_next = '0; cnt_next = '0;
      quote_next = '0; nflags_next = '0; held_next = '0;
      fm = M_IDLE;
      case (c)
        8'h27, 8'h22: begin fm = M_SSTR; quote_next = c; end
        8'h28: begin slot[nres] = '{K_LPAR, 16'd1}; nres = nres + 2'd1; end
        8'h29: begin slot[nres] = '{K_RPAR, 16'd1}; nres = nres + 2'd1; end
        8'h5d: begin slot[nres] = '{K_RBRACK, 16'd1}; nres = nres + 2'd1; end
        8'h7b: begin slot[nres] = '{K_LBRACE, 16'd1}; nres = nres + 2'd1; end
        8'h7d: begin slot[nres] = '{K_RBRACE, 16'd1}; nres = nres + 2'd1; end
        8'h3b: begin slot[nres] = '{K_SEMI, 16'd1}; nres = nres + 2'd1; end
        8'h2c: begin slot[nres] = '{K_COMMA, 16'd1}; nres = nres + 2'd1; end
        8'h2b: begin slot[nres] = '{K_ADD, 16'd1}; nres = nres + 2'd1; end
        8'h2a: begin slot[nres] = '{K_MUL, 16'd1}; nres = nres + 2'd1; end
        8'h2f: begin slot[nres] = '{K_DIV, 16'd1}; nres = nres + 2'd1; end
        8'h25: begin slot[nres] = '{K_MOD, 16'd1}; nres = nres + 2'd1; end
        8'h5e: begin slot[nres] = '{K_POW, 16'd1}; nres = nres + 2'd1; end
        8'h23: begin slot[nres] = '{K_LEN, 16'd1}; nres = nres + 2'd1; end
        8'h7e: fm = M_TILDE;
        8'h3e: fm = M_GT;
        8'h3c: fm = M_LT;
        8'h3d: fm = M_EQ;
        8'h3a: fm = M_COLON;
        8'h2d: fm = M_MINUS;
        8'h2e: fm = M_DOT;
        8'h5b: fm = M_LBRACK;
        default: begin
          if (k.digit) fm = (c == 8'h30) ? M_NUMZERO : M_NUMBER;
          else if (k.namech) begin fm = M_NAME; nbuf_next = 64'(c); end
          else if (!k.space) begin
            slot[nres] = '{K_UNID, 16'd1}; nres = nres + 2'd1;
          end
        end
      endcase
      if (fm != M_IDLE) begin
        mode_next = fm; cnt_next = len_t'(1); held_next = c;
      end
    end

    // end of text: flush pending token, then end of file
    if (q_item.last) begin
      fl = 2'd1;
      case (mode_next)
        M_TILDE: slot[nres] = '{K_UNID, lcap(cnt_next)};
        M_GT:    slot[nres] = '{K_GT, lcap(cnt_next)};
        M_LT:    slot[nres] = '{K_LT, lcap(cnt_next)};
        M_EQ:    slot[nres] = '{K_ASSIGN, lcap(cnt_next)};
        M_COLON: slot[nres] = '{K_COLON, lcap(cnt_next)};
        M_MINUS: slot[nres] = '{K_SUB, lcap(cnt_next)};
        M_DASH2, M_DASH2BR, M_SCOM: slot[nres] = '{K_SCOM, lcap(cnt_next)};
        M_LCOM:  slot[nres] = '{K_LCOM, lcap(cnt_next)};
        M_DOT:   slot[nres] = '{K_ATTR, lcap(cnt_next)};
        M_LBRACK: slot[nres] = '{K_LBRACK, lcap(cnt_next)};
        M_LSTR, M_SSTR, M_SESC: slot[nres] = '{K_USTR, lcap(cnt_next)};
        M_NUMZERO, M_NUMBER:
          slot[nres] = '{nflags_next[0] ? K_FLOAT : K_INT, lcap(cnt_next)};
        M_NAME: slot[nres] = '{(cnt_next > len_t'(NameBytes)) ? K_IDENT :
                                kw_kind(nbuf_next, cnt_next[3:0]), lcap(cnt_next)};
        default: fl = 2'd0;
      endcase
      nres = nres + fl;
      slot[nres] = '{K_EOF, 16'd0};
      nres = nres + 2'd1;
      mode_next = M_IDLE; nbuf_next = '0; cnt_next = '0;
      quote_next = '0; nflags_next = '0; held_next = '0;
    end
  end

  // state and output slot registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      nbuf    <= '0;
      cnt     <= '0;
      quote   <= '0;
      nflags  <= '0;
      held    <= '0;
      busy    <= 1'b0;
      res_n   <= '0;
      res_pos <= '0;
    end else begin
      if (take) begin
        mode <= mode_next; nbuf <= nbuf_next; cnt <= cnt_next;
        quote <= quote_next; nflags <= nflags_next; held <= held_next;
        busy <= (nres != 2'd0);
        res_n <= nres;
        res_pos <= '0;
        for (int i = 0; i < 3; i++) res[i] <= slot[i];
      end else if (busy && out_ready) begin
        if (res_pos + 2'd1 == res_n) busy <= 1'b0;
        else res_pos <= res_pos + 2'd1;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (res_pos < res_n)) else $error("slot index past count");
  a_eof_idle: assert property (@(posedge clk) disable iff (rst)
    (take && q_item.last) |=> (mode == M_IDLE && cnt == '0)) else $error("no reset at eof");
  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_ready) |-> !q_ready) else $error("byte taken while stalled");

endmodule

// File: sim/tb_lua_source_tokenizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lua_source_tokenizer_core
// self-checking bench for the streaming lua tokenizer: directed and random
// source text in, token kind, length and run_end compared against a predictor
// ----------------------------------------------------------------------------
module tb_lua_source_tokenizer_core;
  import lua_tok_pkg::*;

  // lexer modes of the predictor
  typedef enum int {
    LX_IDLE, LX_TILDE, LX_GT, LX_LT, LX_EQ, LX_COLON, LX_MINUS, LX_DASH2, LX_DASH2BR,
    LX_SCOM, LX_LCOM, LX_DOT, LX_LBRACK, LX_LSTR, LX_SSTR, LX_SESC, LX_NUMZERO,
    LX_NUMBER, LX_NAME
  } lex_mode_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] len;
    logic        run_end;
  } token_t;

  localparam int StallLimit = 5000;

  // token predictor and expected-token store
  class token_scoreboard;
    lex_mode_e   mode;
    logic [63:0] name_buf;
    logic [15:0] count;
    logic [7:0]  quote;
    logic [1:0]  nflags;
    logic [7:0]  held;
    token_t      pending_tokens[$];
    token_t      step_tokens[$];
    int          errors;

    function void clear_state();
      mode = LX_IDLE; name_buf = '0; count = '0; quote = '0; nflags = '0; held = '0;
    endfunction

    function void emit_tok(logic [5:0] k, logic [15:0] l);
      token_t t;
      t.kind = k; t.len = l; t.run_end = 1'b0;
      if (step_tokens.size() < 3) step_tokens.push_back(t);
    endfunction

    function void bump();
      if (count != 16'hffff) count++;
    endfunction

    function void close_tok(logic [5:0] k);
      emit_tok(k, count);
      clear_state();
    endfunction

    function logic [5:0] word_kind();
      if (count > NameBytes) return K_IDENT;
      case (count)
        2: case (name_buf[15:0])
             "fi": return 1; "ni": return 2; "ro": return 6; "od": return 20;
             default: ;
           endcase
        3: case (name_buf[23:0])
             "lin": return 3; "ton": return 4; "dna": return 12; "dne": return 15;
             "rof": return 17; default: ;
           endcase
        4: case (name_buf[31:0])
             "neht": return 7; "eurt": return 8; "otog": return 13; "esle": return 18;
             default: ;
           endcase
        5: case (name_buf[39:0])
             "lacol": return 0; "elihw": return 9; "litnu": return 10;
             "eslaf": return 16; "kaerb": return 21; default: ;
           endcase
        6: case (name_buf[47:0])
             "taeper": return 5; "nruter": return 11; "fiesle": return 19;
             default: ;
           endcase
        8: if (name_buf == "noitcnuf") return 14;
        default: ;
      endcase
      return K_IDENT;
    endfunction

    function void open_tok(lex_mode_e m, logic [7:0] c);
      clear_state();
      mode = m; count = 1; held = c;
    endfunction

    function void lex_start(logic [7:0] c);
      case (c)
        "'", "\"": begin open_tok(LX_SSTR, c); quote = c; return; end
        "(": begin emit_tok(K_LPAR, 1); return; end
        ")": begin emit_tok(K_RPAR, 1); return; end
        "]": begin emit_tok(K_RBRACK, 1); return; end
        "{": begin emit_tok(K_LBRACE, 1); return; end
        "}": begin emit_tok(K_RBRACE, 1); return; end
        ";": begin emit_tok(K_SEMI, 1); return; end
        ",": begin emit_tok(K_COMMA, 1); return; end
        "+": begin emit_tok(K_ADD, 1); return; end
        "*": begin emit_tok(K_MUL, 1); return; end
        "/": begin emit_tok(K_DIV, 1); return; end
        "%": begin emit_tok(K_MOD, 1); return; end
        "^": begin emit_tok(K_POW, 1); return; end
        "#": begin emit_tok(K_LEN, 1); return; end
        "~": begin open_tok(LX_TILDE, c); return; end
        ">": begin open_tok(LX_GT, c); return; end
        "<": begin open_tok(LX_LT, c); return; end
        "=": begin open_tok(LX_EQ, c); return; end
        ":": begin open_tok(LX_COLON, c); return; end
        "-": begin open_tok(LX_MINUS, c); return; end
        ".": begin open_tok(LX_DOT, c); return; end
        "[": begin open_tok(LX_LBRACK, c); return; end
        default: ;
      endcase
      if (is_dig(c)) open_tok(c == "0" ? LX_NUMZERO : LX_NUMBER, c);
      else if (is_alp(c) || c == "_") begin
        open_tok(LX_NAME, c);
        name_buf = {56'd0, c};
      end else if (!(c == " " || (c >= 9 && c <= 13))) emit_tok(K_UNID, 1);
    endfunction

    function bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction
    function bit is_alp(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // feed a byte to the pending token; 1 means lex it afresh
    function bit lex_pending(logic [7:0] c);
      bit xd;
      xd = is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      case (mode)
        LX_TILDE: begin if (c == "=") begin bump(); close_tok(K_NE); return 0; end
                    close_tok(K_UNID); return 1; end
        LX_GT: begin if (c == "=") begin bump(); close_tok(K_GE); return 0; end
                 close_tok(K_GT); return 1; end
        LX_LT: begin if (c == "=") begin bump(); close_tok(K_LE); return 0; end
                 close_tok(K_LT); return 1; end
        LX_EQ: begin if (c == "=") begin bump(); close_tok(K_EQ); return 0; end
                 close_tok(K_ASSIGN); return 1; end
        LX_COLON: begin if (c == ":") begin bump(); close_tok(K_DCOLON); return 0; end
                    close_tok(K_COLON); return 1; end
        LX_MINUS: begin
          if (c == "-") begin mode = LX_DASH2; bump(); return 0; end
          if (is_dig(c)) begin mode = LX_NUMBER; nflags = 0; bump(); return 0; end
          close_tok(K_SUB); return 1;
        end
        LX_DASH2, LX_DASH2BR, LX_SCOM: begin
          if (c == 8'h0a) begin close_tok(K_SCOM); return 1; end
          if (c == "[" && mode == LX_DASH2) mode = LX_DASH2BR;
          else if (c == "[" && mode == LX_DASH2BR) begin mode = LX_LCOM; held = c; end
          else mode = LX_SCOM;
          bump(); return 0;
        end
        LX_LCOM, LX_LSTR: begin
          bump();
          if (c == "]" && held == "]") close_tok(mode == LX_LCOM ? K_LCOM : K_STR);
          else held = c;
          return 0;
        end
        LX_DOT: begin
          if (is_dig(c)) begin mode = LX_NUMBER; nflags = 1; bump(); return 0; end
          close_tok(K_ATTR); return 1;
        end
        LX_LBRACK: begin
          if (c == "[") begin mode = LX_LSTR; held = c; bump(); return 0; end
          close_tok(K_LBRACK); return 1;
        end
        LX_SSTR: begin
          bump();
          if (c == "\\") mode = LX_SESC;
          else if (c == quote) close_tok(K_STR);
          return 0;
        end
        LX_SESC: begin bump(); mode = LX_SSTR; return 0; end
        LX_NUMZERO: begin
          mode = LX_NUMBER;
          if (c == "x" || c == "X") begin nflags[1] = 1'b1; bump(); return 0; end
          return lex_pending(c);
        end
        LX_NUMBER: begin
          if (c == ".") begin nflags[0] = 1'b1; bump(); return 0; end
          if (c == "-" || is_dig(c) || c == "e" || c == "E" || (nflags[1] && xd)) begin
            bump(); return 0;
          end
          close_tok(nflags[0] ? K_FLOAT : K_INT); return 1;
        end
        LX_NAME: begin
          if (is_alp(c) || is_dig(c) || c == "_") begin
            if (count < NameBytes) name_buf[8*count +: 8] = c;
            bump(); return 0;
          end
          close_tok(word_kind()); return 1;
        end
        default: begin clear_state(); return 1; end
      endcase
    endfunction

    function void close_run();
      case (mode)
        LX_IDLE: ;
        LX_TILDE: close_tok(K_UNID);
        LX_GT: close_tok(K_GT);
        LX_LT: close_tok(K_LT);
        LX_EQ: close_tok(K_ASSIGN);
        LX_COLON: close_tok(K_COLON);
        LX_MINUS: close_tok(K_SUB);
        LX_DASH2, LX_DASH2BR, LX_SCOM: close_tok(K_SCOM);
        LX_LCOM: close_tok(K_LCOM);
        LX_DOT: close_tok(K_ATTR);
        LX_LBRACK: close_tok(K_LBRACK);
        LX_LSTR, LX_SSTR, LX_SESC: close_tok(K_USTR);
        LX_NUMZERO, LX_NUMBER: close_tok(nflags[0] ? K_FLOAT : K_INT);
        LX_NAME: close_tok(word_kind());
        default: ;
      endcase
      clear_state();
    endfunction

    // note an accepted byte
    function void note_byte(logic [7:0] c, logic fin);
      step_tokens.delete();
      if (mode == LX_IDLE || lex_pending(c)) lex_start(c);
      if (fin) begin
        close_run();
        emit_tok(K_EOF, 0);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].run_end = 1'b1;
      foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endfunction

    // check an accepted token
    function void check_token(logic [5:0] k, logic [15:0] l, logic re);
      token_t e;
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token kind=%0d len=%0d run_end=%0d", $time, k, l, re);
        errors++;
        return;
      end
      e = pending_tokens.pop_front();
      if (e.kind !== k || e.len !== l || e.run_end !== re) begin
        $display("%0t: token mismatch expected kind=%0d len=%0d run_end=%0d,",
                 $time, e.kind, e.len, e.run_end);
        $display("    actual kind=%0d len=%0d run_end=%0d", k, l, re);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  token_scoreboard sb = new();
  bit   gaps_on = 1'b1;
  bit   hold_sink = 1'b0;
  bit   done_feed = 1'b0;
  int   idle_cycles = 0;
  byte  text_q[$];

  lua_source_tokenizer_core DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_token(m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // sink with random stalls
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic fin);
    int n;
    if (gaps_on && $urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // send the queued text, last byte flagged when fin is set
  task automatic send_text(input bit fin);
    foreach (text_q[i]) send_byte(text_q[i], fin && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  task automatic queue_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_tokens.size() != 0) @(posedge clk);
  endtask

  // random lua-like fragment
  task automatic queue_fragment();
    string frags[] = '{"local ", "if ", "in ", "nil ", "not ", "repeat ", "or ", "then ",
      "true ", "while ", "until ", "return ", "and ", "goto ", "function ", "end ",
      "false ", "for ", "else ", "elseif ", "do ", "break ", "x1_y ", "functions ",
      "abcdefghij ", "0x1F ", "0XaB.c ", "3.5e-2 ", "-7 ", ".5 ", "123 ", "'a\\'b' ",
      "\"s\nt\" ", "[[long]] ", "--c\n", "--[[lc]]]] ", "~= ", ">= ", "<= ", "== ",
      "~ ", "> ", "< ", "= ", ":: ", ": ", "a.b", "(", ")", "[", "]", "{", "}", ";",
      ",", "+", "*", "/", "%", "^", "#", "-", "\t", "\n", "a=b", "[x]", "x-y"};
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) text_q.push_back(byte'($urandom_range(0, 255)));
    else queue_str(frags[$urandom_range(0, frags.size() - 1)]);
  endtask

  initial begin
    int sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: operators, keywords, numbers, strings, comments, odd bytes
    queue_str("local x=0x1F ~= -3.5;");
    send_text(1'b0);
    queue_str("function functionx ~a>b<=c :: d.e .5 [[s]] --[[c]] --x\n");
    send_text(1'b0);
    text_q.push_back(8'hff); text_q.push_back(8'h00); text_q.push_back(8'h80);
    queue_str("'q\\'\"");
    send_text(1'b1);
    send_byte("x", 1'b1);
    send_byte("~", 1'b1);
    send_byte(8'h7f, 1'b1);

    // sender pauses until everything has come out
    drain_all();

    // long receiver hold while the sender keeps offering bytes
    hold_sink = 1'b1;
    fork
      begin repeat (200) @(posedge clk); hold_sink = 1'b0; end
      begin queue_str("a+b*c-(d)/e,f;g^h#i%j{k}"); send_text(1'b0); end
    join

    // random part: mostly well-formed fragments
    sent = 0;
    while (sent < 336) begin
      queue_fragment();
      sent += text_q.size();
      if (sent > 280) gaps_on = 1'b0;
      send_text($urandom_range(0, 15) == 0);
    end
    queue_str("end");
    send_text(1'b1);

    drain_all();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_tokens.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/lua_tok_pkg.sv
hw/rtl/lua_tok_front.sv
hw/rtl/lua_tok_back.sv
hw/rtl/lua_source_tokenizer_core.sv
sim/tb_lua_source_tokenizer_core.sv
